### rtl/polyline_corner_detector_defines.svh
// Assertion helpers for the corner detector checker.
`ifndef POLYLINE_CORNER_DETECTOR_DEFINES_SVH
`define POLYLINE_CORNER_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pcd_pkg.sv
package pcd_pkg;

    // Port widths
    localparam int PT_W      = 32;
    localparam int IDX_OUT_W = 16;
    localparam int COS_W     = 15;
    localparam logic [COS_W-1:0] COS_RESET = 15'd18795;

    // Datapath widths (sized for the widest coordinate)
    localparam int MAG_W    = 32;           // segment component magnitude
    localparam int OPND_W   = 33;           // shared multiplier operand
    localparam int PROD_W   = 2 * OPND_W;   // multiplier product
    localparam int SLICE    = OPND_W;       // chunk size for wide operands
    localparam int PP_W     = 2 * MAG_W;    // component product
    localparam int DOT_W    = PP_W + 1;     // |dot product|
    localparam int LEN_W    = PP_W + 1;     // squared segment length
    localparam int CSQ_W    = 2 * COS_W;    // cos threshold squared
    localparam int Q_W      = LEN_W + CSQ_W;
    localparam int LHS_W    = 2 * DOT_W;
    localparam int LHS_SHIFT = 2 * COS_W;   // 32768^2 scale on dot^2
    localparam int ACC_W    = LHS_W + LHS_SHIFT;

    // Accumulator alignment of a partial product
    typedef enum logic [2:0] {
        SH_0,
        SH_33,
        SH_34,
        SH_66,
        SH_99
    } mac_shift_t;

    typedef struct packed {
        logic       acc_en;
        logic       acc_clr;
        mac_shift_t shift;
    } mac_ctrl_t;

    // Sequencer steps; each step that multiplies issues one multiply
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_UVX,      // ux*vx
        ST_UVY,      // uy*vy
        ST_DOT,      // dot sign/magnitude, ux*ux
        ST_LEN_UY,   // uy*uy
        ST_LEN_VX,   // vx*vx
        ST_LEN_VY,   // vy*vy
        ST_COS_SQ,   // cos*cos
        ST_LHS0,     // dl*dl
        ST_LHS1,     // dh*dl, doubled
        ST_LHS2,     // dh*dh
        ST_Q0,       // lu_lo*c2
        ST_Q1,       // lu_hi*c2
        ST_QWAIT,
        ST_QLATCH,
        ST_R0,
        ST_R1,
        ST_R2,
        ST_R3,
        ST_R4,
        ST_R5,
        ST_RWAIT,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

### rtl/pcd_mac.sv
module pcd_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pcd_pkg::OPND_W-1:0]    opnd_a,
    input  logic [pcd_pkg::OPND_W-1:0]    opnd_b,
    input  pcd_pkg::mac_ctrl_t            ctrl,
    output logic [pcd_pkg::PROD_W-1:0]    prod,
    output logic [pcd_pkg::ACC_W-1:0]     acc
);
    import pcd_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    mac_ctrl_t         ctrl_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [ACC_W-1:0]  prod_ext;
    logic [ACC_W-1:0]  prod_aligned;

    // Multiply stage: product registered with its accumulate control
    always_ff @(posedge clk)
    begin
        prod_reg <= opnd_a * opnd_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '{acc_en: 1'b0, acc_clr: 1'b0, shift: SH_0};
        end
        else
        begin
            ctrl_reg <= ctrl;
        end
    end

    // Align the product within the wide accumulator
    assign prod_ext = ACC_W'(prod_reg);

    always_comb
    begin
        case (ctrl_reg.shift)
            SH_0:    prod_aligned = prod_ext;
            SH_33:   prod_aligned = prod_ext << 33;
            SH_34:   prod_aligned = prod_ext << 34;
            SH_66:   prod_aligned = prod_ext << 66;
            SH_99:   prod_aligned = prod_ext << 99;
            default: prod_aligned = prod_ext;
        endcase
    end

    // Accumulate stage
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl_reg.acc_en)
        begin
            acc_next = (ctrl_reg.acc_clr ? '0 : acc_reg) + prod_aligned;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

### rtl/polyline_corner_detector.sv
// Polyline corner detector.
// Points arrive on the point channel (point_valid / point_stall); starts_line
// marks the first point of a new polyline. For each interior point the turn
// between the incoming and outgoing segments is tested exactly against the
// threshold in cos_reg; a sharp turn yields that point's index in
// its line on the corner channel (corner_valid / corner_stall).
// The user must write the threshold through cfg_valid / cfg_ready / cfg_data
// only while the block is idle; the block itself does not enforce this.
// cfg_ready is always high. The first two points of a line are taken without
// a test. Every later point starts a test that holds point_stall high until it
// ends, ending early when the turn is past 90 degrees; the test runs on one
// 33x33 multiplier shared over the dot product, segment lengths and the scaled
// compare. A corner shows on the output the cycle after the test ends.
// While a corner waits in the output register the next point is still taken;
// only the end of a later test that finds a corner waits for the receiver.
// Reset clears the line (next point starts index 0), the output valid and
// sets the threshold to cos(55 deg) in Q0.15.
module polyline_corner_detector #(
    parameter int COORD_WIDTH = 32,
    parameter int INDEX_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             point_valid,
    output logic                             point_stall,
    input  logic signed [pcd_pkg::PT_W-1:0]  point_x,
    input  logic signed [pcd_pkg::PT_W-1:0]  point_y,
    input  logic                             starts_line,
    output logic                             corner_valid,
    input  logic                             corner_stall,
    output logic [pcd_pkg::IDX_OUT_W-1:0]    corner_index,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pcd_pkg::COS_W-1:0]        cfg_data
);
    import pcd_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int IDX_EXT_W = (INDEX_WIDTH > IDX_OUT_W) ? INDEX_WIDTH : IDX_OUT_W;

    state_t state_reg, state_next;

    logic [COS_W-1:0]               cos_reg;
    logic signed [COORD_WIDTH-1:0]  older_x_reg, older_y_reg, middle_x_reg, middle_y_reg;
    logic [INDEX_WIDTH-1:0]         seen_reg, seen_next;
    logic [MAG_W-1:0]               ux_reg, uy_reg, vx_reg, vy_reg;
    logic                           nux_reg, nuy_reg, nvx_reg, nvy_reg;
    logic [PP_W-1:0]                p1_reg;
    logic [DOT_W-1:0]               dot_reg;
    logic [LEN_W-1:0]               lu_reg, lv_reg;
    logic [CSQ_W-1:0]               c2_reg;
    logic [LHS_W-1:0]               lhs_reg;
    logic [Q_W-1:0]                 q_reg;
    logic                           corner_reg;
    logic [IDX_OUT_W-1:0]           idx_reg;
    logic                           corner_valid_reg, corner_valid_next;
    logic [IDX_OUT_W-1:0]           corner_index_reg;

    logic                           accept, line_start, run_test, out_load;
    logic signed [COORD_WIDTH-1:0]  new_x, new_y;
    logic signed [DW-1:0]           dux, duy, dvx, dvy;
    logic [COORD_WIDTH-1:0]         mux, muy, mvx, mvy;
    logic [MAG_W-1:0]               ux_fix, vx_fix;
    logic [IDX_EXT_W-1:0]           idx_full;

    logic [DOT_W-1:0]               p_sum, p_diff;
    logic [DOT_W-1:0]               dot_calc;
    logic                           s1, s2, dneg_raw, dneg;

    logic [OPND_W-1:0]              mac_a, mac_b;
    mac_ctrl_t                      mac_ctrl;
    logic [PROD_W-1:0]              mac_prod;
    logic [ACC_W-1:0]               mac_acc;

    pcd_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .opnd_a (mac_a),
        .opnd_b (mac_b),
        .ctrl   (mac_ctrl),
        .prod   (mac_prod),
        .acc    (mac_acc)
    );

    // Handshakes
    assign point_stall = (state_reg != ST_IDLE);
    assign accept      = point_valid && !point_stall;
    assign cfg_ready   = 1'b1;
    assign line_start  = starts_line || (seen_reg == '0);
    assign run_test    = accept && !line_start && (seen_reg >= INDEX_WIDTH'(2));

    // Incoming point, low COORD_WIDTH bits taken
    assign new_x = point_x[COORD_WIDTH-1:0];
    assign new_y = point_y[COORD_WIDTH-1:0];

    // Segment vectors u = middle - older, v = new - middle
    assign dux = DW'(middle_x_reg) - DW'(older_x_reg);
    assign duy = DW'(middle_y_reg) - DW'(older_y_reg);
    assign dvx = DW'(new_x) - DW'(middle_x_reg);
    assign dvy = DW'(new_y) - DW'(middle_y_reg);

    assign mux = dux[DW-1] ? COORD_WIDTH'(-dux) : COORD_WIDTH'(dux);
    assign muy = duy[DW-1] ? COORD_WIDTH'(-duy) : COORD_WIDTH'(duy);
    assign mvx = dvx[DW-1] ? COORD_WIDTH'(-dvx) : COORD_WIDTH'(dvx);
    assign mvy = dvy[DW-1] ? COORD_WIDTH'(-dvy) : COORD_WIDTH'(dvy);

    // Zero-length segment heads along +x
    assign ux_fix = ((mux == '0) && (muy == '0)) ? MAG_W'(1) : MAG_W'(mux);
    assign vx_fix = ((mvx == '0) && (mvy == '0)) ? MAG_W'(1) : MAG_W'(mvx);

    assign idx_full = IDX_EXT_W'(seen_reg - INDEX_WIDTH'(1));

    // Line position counter, saturating
    always_comb
    begin
        seen_next = seen_reg;
        if (accept)
        begin
            if (line_start)
            begin
                seen_next = INDEX_WIDTH'(1);
            end
            else if (seen_reg != '1)
            begin
                seen_next = seen_reg + INDEX_WIDTH'(1);
            end
        end
    end

    // Signed dot product from the two component products
    assign s1     = nux_reg ^ nvx_reg;
    assign s2     = nuy_reg ^ nvy_reg;
    assign p_sum  = DOT_W'(p1_reg) + DOT_W'(mac_prod[PP_W-1:0]);
    assign p_diff = DOT_W'(p1_reg) - DOT_W'(mac_prod[PP_W-1:0]);

    always_comb
    begin
        if (s1 == s2)
        begin
            dot_calc = p_sum;
            dneg_raw = s1;
        end
        else if (!p_diff[DOT_W-1])
        begin
            dot_calc = p_diff;
            dneg_raw = s1;
        end
        else
        begin
            dot_calc = -p_diff;
            dneg_raw = s2;
        end
        dneg = dneg_raw && (dot_calc != '0);
    end

    // Sequencer: next step and shared multiplier operands
    always_comb
    begin
        state_next = state_reg;
        mac_a      = '0;
        mac_b      = '0;
        mac_ctrl   = '{acc_en: 1'b0, acc_clr: 1'b0, shift: SH_0};
        case (state_reg)
            ST_IDLE:
            begin
                if (run_test)
                begin
                    state_next = ST_UVX;
                end
            end
            ST_UVX:
            begin
                mac_a = OPND_W'(ux_reg);
                mac_b = OPND_W'(vx_reg);
                state_next = ST_UVY;
            end
            ST_UVY:
            begin
                mac_a = OPND_W'(uy_reg);
                mac_b = OPND_W'(vy_reg);
                state_next = ST_DOT;
            end
            ST_DOT:
            begin
                mac_a = OPND_W'(ux_reg);
                mac_b = OPND_W'(ux_reg);
                state_next = dneg ? ST_DONE : ST_LEN_UY;
            end
            ST_LEN_UY:
            begin
                mac_a = OPND_W'(uy_reg);
                mac_b = OPND_W'(uy_reg);
                state_next = ST_LEN_VX;
            end
            ST_LEN_VX:
            begin
                mac_a = OPND_W'(vx_reg);
                mac_b = OPND_W'(vx_reg);
                state_next = ST_LEN_VY;
            end
            ST_LEN_VY:
            begin
                mac_a = OPND_W'(vy_reg);
                mac_b = OPND_W'(vy_reg);
                state_next = ST_COS_SQ;
            end
            ST_COS_SQ:
            begin
                mac_a = OPND_W'(cos_reg);
                mac_b = OPND_W'(cos_reg);
                state_next = ST_LHS0;
            end
            // dot^2 = dl^2 + 2*dh*dl*2^33 + dh^2*2^66
            ST_LHS0:
            begin
                mac_a = dot_reg[SLICE-1:0];
                mac_b = dot_reg[SLICE-1:0];
                mac_ctrl = '{acc_en: 1'b1, acc_clr: 1'b1, shift: SH_0};
                state_next = ST_LHS1;
            end
            ST_LHS1:
            begin
                mac_a = OPND_W'(dot_reg[DOT_W-1:SLICE]);
                mac_b = dot_reg[SLICE-1:0];
                mac_ctrl = '{acc_en: 1'b1, acc_clr: 1'b0, shift: SH_34};
                state_next = ST_LHS2;
            end
            ST_LHS2:
            begin
                mac_a = OPND_W'(dot_reg[DOT_W-1:SLICE]);
                mac_b = OPND_W'(dot_reg[DOT_W-1:SLICE]);
                mac_ctrl = '{acc_en: 1'b1, acc_clr: 1'b0, shift: SH_66};
                state_next = ST_Q0;
            end
            // q = |u|^2 * cos^2
            ST_Q0:
            begin
                mac_a = lu_reg[SLICE-1:0];
                mac_b = OPND_W'(c2_reg);
                mac_ctrl = '{acc_en: 1'b1, acc_clr: 1'b1, shift: SH_0};
                state_next = ST_Q1;
            end
            ST_Q1:
            begin
                mac_a = OPND_W'(lu_reg[LEN_W-1:SLICE]);
                mac_b = OPND_W'(c2_reg);
                mac_ctrl = '{acc_en: 1'b1, acc_clr: 1'b0, shift: SH_33};
                state_next = ST_QWAIT;
            end
            ST_QWAIT:
            begin
                state_next = ST_QLATCH;
            end
            ST_QLATCH:
            begin
                state_next = ST_R0;
            end
            // rhs = q * |v|^2, three q chunks by two lv chunks
            ST_R0:
            begin
                mac_a = q_reg[SLICE-1:0];
                mac_b = lv_reg[SLICE-1:0];
                mac_ctrl = '{acc_en: 1'b1, acc_clr: 1'b1, shift: SH_0};
                state_next = ST_R1;
            end
            ST_R1:
            begin
                mac_a = q_reg[SLICE-1:0];
                mac_b = OPND_W'(lv_reg[LEN_W-1:SLICE]);
                mac_ctrl = '{acc_en: 1'b1, acc_clr: 1'b0, shift: SH_33};
                state_next = ST_R2;
            end
            ST_R2:
            begin
                mac_a = q_reg[2*SLICE-1:SLICE];
                mac_b = lv_reg[SLICE-1:0];
                mac_ctrl = '{acc_en: 1'b1, acc_clr: 1'b0, shift: SH_33};
                state_next = ST_R3;
            end
            ST_R3:
            begin
                mac_a = q_reg[2*SLICE-1:SLICE];
                mac_b = OPND_W'(lv_reg[LEN_W-1:SLICE]);
                mac_ctrl = '{acc_en: 1'b1, acc_clr: 1'b0, shift: SH_66};
                state_next = ST_R4;
            end
            ST_R4:
            begin
                mac_a = OPND_W'(q_reg[Q_W-1:2*SLICE]);
                mac_b = lv_reg[SLICE-1:0];
                mac_ctrl = '{acc_en: 1'b1, acc_clr: 1'b0, shift: SH_66};
                state_next = ST_R5;
            end
            ST_R5:
            begin
                mac_a = OPND_W'(q_reg[Q_W-1:2*SLICE]);
                mac_b = OPND_W'(lv_reg[LEN_W-1:SLICE]);
                mac_ctrl = '{acc_en: 1'b1, acc_clr: 1'b0, shift: SH_99};
                state_next = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!corner_reg || !corner_valid_reg || !corner_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            seen_reg         <= '0;
            cos_reg          <= COS_RESET;
            corner_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            seen_reg         <= seen_next;
            corner_valid_reg <= corner_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cos_reg <= cfg_data;
            end
        end
    end

    // Point history and segment vectors
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            older_x_reg  <= middle_x_reg;
            older_y_reg  <= middle_y_reg;
            middle_x_reg <= new_x;
            middle_y_reg <= new_y;
            ux_reg       <= ux_fix;
            uy_reg       <= MAG_W'(muy);
            vx_reg       <= vx_fix;
            vy_reg       <= MAG_W'(mvy);
            nux_reg      <= dux[DW-1];
            nuy_reg      <= duy[DW-1];
            nvx_reg      <= dvx[DW-1];
            nvy_reg      <= dvy[DW-1];
            idx_reg      <= idx_full[IDX_OUT_W-1:0];
        end
    end

    // Results of the shared multiplier, captured per step
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_UVY:    p1_reg     <= mac_prod[PP_W-1:0];
            ST_DOT:
            begin
                dot_reg    <= dot_calc;
                corner_reg <= dneg;
            end
            ST_LEN_UY: lu_reg     <= LEN_W'(mac_prod);
            ST_LEN_VX: lu_reg     <= lu_reg + LEN_W'(mac_prod);
            ST_LEN_VY: lv_reg     <= LEN_W'(mac_prod);
            ST_COS_SQ: lv_reg     <= lv_reg + LEN_W'(mac_prod);
            ST_LHS0:   c2_reg     <= CSQ_W'(mac_prod);
            ST_Q1:     lhs_reg    <= mac_acc[LHS_W-1:0];
            ST_QLATCH: q_reg      <= mac_acc[Q_W-1:0];
            ST_CMP:    corner_reg <= ({lhs_reg, LHS_SHIFT'(0)} < mac_acc);
            default:   ;
        endcase
    end

    // Output register
    assign out_load = (state_reg == ST_DONE) && corner_reg &&
                      (!corner_valid_reg || !corner_stall);

    always_comb
    begin
        corner_valid_next = corner_valid_reg && corner_stall;
        if (out_load)
        begin
            corner_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            corner_index_reg <= idx_reg;
        end
    end

    assign corner_valid = corner_valid_reg;
    assign corner_index = corner_index_reg;

endmodule

### rtl/pcd_checker.sv
`include "polyline_corner_detector_defines.svh"

module pcd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             point_valid,
    input logic                             point_stall,
    input logic signed [pcd_pkg::PT_W-1:0]  point_x,
    input logic signed [pcd_pkg::PT_W-1:0]  point_y,
    input logic                             starts_line,
    input logic                             corner_valid,
    input logic                             corner_stall,
    input logic [pcd_pkg::IDX_OUT_W-1:0]    corner_index,
    input logic                             cfg_valid,
    input logic                             cfg_ready
);
    import pcd_pkg::*;

    logic cfg_xact;

    assign cfg_xact = cfg_valid && cfg_ready;

    // A stalled point holds its payload
    `PCD_ASSERT_NEXT(a_point_hold, clk, rst_n, point_valid && point_stall,
        point_valid && $stable(point_x) && $stable(point_y) && $stable(starts_line),
        "point payload changed while stalled")

    // A stalled corner holds its index
    `PCD_ASSERT_NEXT(a_corner_hold, clk, rst_n, corner_valid && corner_stall,
        corner_valid && $stable(corner_index), "corner result changed while stalled")

    // A new corner appears only at the end of a test, while points are held off
    `PCD_ASSERT_NOW(a_corner_after_test, clk, rst_n, $rose(corner_valid),
        $past(point_stall), "corner appeared outside a test")

    // A test keeps point_stall high past the cycle in which it rises
    `PCD_ASSERT_NEXT(a_test_length, clk, rst_n, $rose(point_stall),
        point_stall, "test ended after a single cycle")

    // The threshold changes only while no test runs
    `PCD_ASSERT_NOW(a_cfg_idle, clk, rst_n, cfg_xact,
        !point_stall, "threshold written during a test")

endmodule

bind polyline_corner_detector pcd_checker u_pcd_checker (.*);

### tb/sv/polyline_corner_detector_tb.sv
module polyline_corner_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = pcd_pkg::PT_W;
    localparam int IW = pcd_pkg::IDX_OUT_W;
    localparam int TW = pcd_pkg::COS_W;

    localparam int RANDOM_ITEMS     = 880;
    localparam int LONG_LINE_POINTS = 40;
    localparam int SETTLE_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int MAX_IDLE         = 6;

    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 point_valid;
    logic                 point_stall;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic                 starts_line;
    logic                 corner_valid;
    logic                 corner_stall;
    logic [IW-1:0]        corner_index;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [TW-1:0]        cfg_data;

    // Shadow of the block: threshold, last two points, points in the line
    logic [TW-1:0]        cos_limit = pcd_pkg::COS_RESET;
    logic signed [CW-1:0] prev_x = '0;
    logic signed [CW-1:0] prev_y = '0;
    logic signed [CW-1:0] last_x = '0;
    logic signed [CW-1:0] last_y = '0;
    logic [IW-1:0]        line_len = '0;
    logic [IW-1:0]        pending_corners[$];

    int            max_gap = MAX_IDLE;
    int            max_stall = MAX_IDLE;
    int            hold_left = 0;
    int            error_count = 0;
    int            sent_count = 0;
    int            stuck_cycles;
    logic [IW-1:0] expected_index;

    polyline_corner_detector u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .starts_line  (starts_line),
        .corner_valid (corner_valid),
        .corner_stall (corner_stall),
        .corner_index (corner_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Exact turn test: dot*32768 < cos * |u| * |v|, squared when dot >= 0
    function automatic bit sharp_turn(
        input logic signed [CW-1:0] ax, ay, bx, by, cx, cy,
        input logic [TW-1:0]        cos_q15
    );
        logic signed [CW+1:0]   ux, uy, vx, vy;
        logic signed [2*CW+7:0] dot, sq_u, sq_v;
        logic [191:0]           dot_w, len_u, len_v, csq, lhs, rhs;
        ux = bx - ax;
        uy = by - ay;
        vx = cx - bx;
        vy = cy - by;
        // zero-length segment heads along +x
        if (ux == 0 && uy == 0)
            ux = 1;
        if (vx == 0 && vy == 0)
            vx = 1;
        dot = ux * vx + uy * vy;
        if (dot < 0)
            return 1'b1;
        sq_u  = ux * ux + uy * uy;
        sq_v  = vx * vx + vy * vy;
        dot_w = {{(192-(2*CW+8)){1'b0}}, dot};
        len_u = {{(192-(2*CW+8)){1'b0}}, sq_u};
        len_v = {{(192-(2*CW+8)){1'b0}}, sq_v};
        csq   = {{(192-TW){1'b0}}, cos_q15};
        lhs   = (dot_w * dot_w) << 30;
        rhs   = len_u * len_v * (csq * csq);
        return lhs < rhs;
    endfunction

    // Advance the shadow line by one point, queue the corner it reveals
    task automatic track_point(
        input logic signed [CW-1:0] x, y,
        input logic                 start
    );
        if (start || line_len == 0)
            line_len = 1;
        else
        begin
            if (line_len >= 2 && sharp_turn(prev_x, prev_y, last_x, last_y, x, y, cos_limit))
                pending_corners = {pending_corners, IW'(line_len - 1'b1)};
            if (line_len != {IW{1'b1}})
                line_len = line_len + 1'b1;
        end
        prev_x = last_x;
        prev_y = last_y;
        last_x = x;
        last_y = y;
    endtask

    // One point transaction; valid stays high when the next one follows at once
    task automatic send_point(
        input logic signed [CW-1:0] x, y,
        input logic                 start
    );
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_valid <= 1'b1;
        point_x     <= x;
        point_y     <= y;
        starts_line <= start;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        track_point(x, y, start);
        sent_count++;
    endtask

    task automatic hold_points();
        point_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Sender stops until every corner has come, then the block drains
    task automatic settle();
        hold_points();
        while (pending_corners.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [TW-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cos_limit = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [CW-1:0] rand_span();
        logic signed [CW-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 3))
            0:       return r;
            1:       return r >>> 8;
            2:       return r >>> 20;
            default: return r >>> 26;
        endcase
    endfunction

    function automatic logic [TW-1:0] pick_threshold();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return {TW{1'b1}};
            2:       return pcd_pkg::COS_RESET;
            3:       return 15'd1;
            4:       return 15'd23170;  // 45 deg
            5:       return 15'd28378;  // 30 deg
            6:       return 15'd5690;   // 80 deg
            default: return TW'($urandom_range(0, 32767));
        endcase
    endfunction

    // Default threshold; the first point comes without starts_line
    task automatic test_reset_defaults();
        max_gap   = MAX_IDLE;
        max_stall = MAX_IDLE;
        send_point(0, 0, 1'b0);
        send_point(100, 0, 1'b0);
        send_point(100, 100, 1'b0);   // right angle
        send_point(100, 200, 1'b0);   // straight
        send_point(150, 250, 1'b0);   // 45 deg
        send_point(150, 250, 1'b0);   // zero-length outgoing
        send_point(150, 250, 1'b0);   // both zero-length
        send_point(0, 250, 1'b0);     // reversal after zero-length
    endtask

    // Full-scale coordinates, then a new line started mid-stream
    task automatic test_extreme_coords();
        send_point(COORD_MIN, COORD_MIN, 1'b1);
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MAX, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(5, 5, 1'b1);
        send_point(6, 5, 1'b0);
        send_point(5, 5, 1'b0);
    endtask

    // Threshold of zero and the largest threshold
    task automatic test_threshold_extremes();
        write_threshold('0);
        send_point(0, 0, 1'b1);
        send_point(10, 0, 1'b0);
        send_point(10, 10, 1'b0);     // exactly 90 deg
        send_point(10, 20, 1'b0);
        send_point(10, 0, 1'b0);
        write_threshold({TW{1'b1}});
        send_point(0, 0, 1'b1);
        send_point(10, 0, 1'b0);
        send_point(20, 0, 1'b0);      // collinear
        send_point(30, 1, 1'b0);      // slight bend
        send_point(40, 2, 1'b0);
    endtask

    // Mostly well-formed lines with random content, some noise between them
    task automatic test_random_lines();
        int                   target, next_phase, len, pick, j;
        logic signed [CW-1:0] px, py, dx, dy;
        target     = sent_count + RANDOM_ITEMS;
        next_phase = sent_count;
        dx = 1;
        dy = 0;
        while (sent_count < target)
        begin
            if (sent_count >= next_phase)
            begin
                write_threshold(pick_threshold());
                max_gap    = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
                max_stall  = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
                next_phase = sent_count + 150;
            end
            if ($urandom_range(0, 9) == 0)
                send_point($urandom, $urandom, 1'($urandom_range(0, 1)));
            else
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                px = rand_span();
                py = rand_span();
                send_point(px, py, 1'b1);
                for (int i = 1; i < len; i++)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                    begin
                        // repeated point
                        dx = 0;
                        dy = 0;
                    end
                    else if (pick == 1)
                    begin
                        dx = -dx;
                        dy = -dy;
                    end
                    else if (pick < 5)
                    begin
                        // near the previous heading
                        j  = $urandom_range(0, 6);
                        dx = dx + j - 3;
                        j  = $urandom_range(0, 6);
                        dy = dy + j - 3;
                    end
                    else
                    begin
                        dx = rand_span();
                        dy = rand_span();
                    end
                    px = px + dx;
                    py = py + dy;
                    send_point(px, py, 1'b0);
                end
            end
        end
        settle();
    endtask

    // Back-and-forth line with no idle cycles, a corner at every interior point
    task automatic test_long_line();
        max_gap   = 0;
        max_stall = 0;
        write_threshold(pcd_pkg::COS_RESET);
        for (int i = 0; i < LONG_LINE_POINTS; i++)
            send_point(i % 2, 0, i == 0);
        settle();
    endtask

    // Corner receiver: stalls a drawn number of cycles per transaction, checks each one
    always @(posedge clk)
    begin
        if (!rst_n)
            corner_stall <= 1'b0;
        else
        begin
            if (corner_valid && !corner_stall)
            begin
                if (pending_corners.size() == 0)
                begin
                    $display("%0t: unexpected corner, expected none, actual index %0d",
                             $time, corner_index);
                    error_count++;
                end
                else
                begin
                    expected_index = pending_corners.pop_front();
                    if (corner_index !== expected_index)
                    begin
                        $display("%0t: corner_index mismatch, expected %0d, actual %0d",
                                 $time, expected_index, corner_index);
                        error_count++;
                    end
                end
                hold_left = $urandom_range(0, max_stall);
            end
            else if (corner_valid && hold_left > 0)
                hold_left--;
            corner_stall <= (hold_left > 0);
        end
    end

    // Watchdog on cycles without any transaction
    initial
    begin
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((point_valid && !point_stall) || (corner_valid && !corner_stall)
                || (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        point_valid <= 1'b0;
        point_x     <= '0;
        point_y     <= '0;
        starts_line <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_extreme_coords();
        test_threshold_extremes();
        test_random_lines();
        test_long_line();

        settle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/pcd_pkg.sv
rtl/pcd_mac.sv
rtl/polyline_corner_detector.sv
rtl/pcd_checker.sv
tb/sv/polyline_corner_detector_tb.sv
